[hw/rtl/dam_pkg.sv]
// Shared constants, status codes and cell interface types for the address map.
`default_nettype none
package dam_pkg;
	localparam int MAP_ENTRIES = 8;
	localparam int IDX_W = $clog2(MAP_ENTRIES);

	localparam logic [15:0] ANNOUNCE_DEST = 16'hfffd;
	localparam logic [15:0] SHORT_MAX = 16'hfff7;
	localparam logic [7:0] MIN_LENGTH = 8'd12;
	localparam logic [63:0] LONG_UNKNOWN = 64'hffff_ffff_ffff_ffff;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FORMAT = 2'd1;
	localparam logic [1:0] ST_CONFLICT = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	localparam logic [1:0] REG_OWN_LONG = 2'd0;
	localparam logic [1:0] REG_CENTER_LONG = 2'd1;
	localparam logic [1:0] REG_OWN_SHORT = 2'd2;

	typedef struct packed {
		logic active;
		logic found_v;
		logic [IDX_W-1:0] found_idx;
		logic found_clash;
		logic free_v;
		logic [IDX_W-1:0] free_idx;
		logic conflict;
	} scan_rec_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
		logic [63:0] lng;
		logic [15:0] short_addr;
	} wr_t;

	typedef struct packed {
		logic en;
		logic [63:0] lng;
		logic [15:0] short_addr;
	} seed_t;
endpackage
`default_nettype wire

[hw/rtl/dam_cell.sv]
// One address map entry that checks a passing scan record and hands it on.
`default_nettype none
module dam_cell import dam_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [IDX_W-1:0] idx,
	input wire logic [15:0] ann_short,
	input wire logic [63:0] ann_long,
	input wire seed_t seed,
	input wire wr_t wr,
	input wire scan_rec_t rec_in,
	output scan_rec_t rec_out
);
	logic [63:0] entry_long_q;
	logic [15:0] entry_short_q;
	logic used_q;
	logic valid_q;
	scan_rec_t rec_d;
	logic low_entry;
	logic match;
	logic clash;

	assign low_entry = (idx < IDX_W'(2));
	assign match = used_q && (entry_long_q == ann_long);
	assign clash = used_q && !match && valid_q && (entry_short_q == ann_short);

	always_comb begin
		rec_d = rec_in;
		if (rec_in.active) begin
			if (!used_q) begin
				rec_d.free_v = 1'b1;
				rec_d.free_idx = idx;
			end else if (match) begin
				rec_d.found_v = 1'b1;
				rec_d.found_idx = idx;
				rec_d.found_clash = low_entry && (entry_short_q != ann_short);
			end else if (clash && low_entry) begin
				rec_d.conflict = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_out <= '0;
			used_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			rec_out <= rec_d;
			if (seed.en) begin
				used_q <= 1'b1;
				valid_q <= 1'b1;
			end else if (wr.en && wr.idx == idx) begin
				used_q <= 1'b1;
				valid_q <= 1'b1;
			end else if (rec_in.active && clash) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seed.en) begin
			entry_long_q <= seed.lng;
			entry_short_q <= seed.short_addr;
		end else if (wr.en && wr.idx == idx) begin
			entry_long_q <= wr.lng;
			entry_short_q <= wr.short_addr;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/device_announce_address_map.sv]
// Top level of the device announce address map: control, registers and the cell chain.
// A malformed announce gives its result in the cycle after the transaction is accepted.
// A well-formed announce is registered into inject_q, then its scan record walks the chain
// of entry cells at one cell per cycle; the result is registered into done_q after the last cell.
// A new announce can be accepted in the cycle its result is shown; the receiver cannot stall.
// Reset clears all entries, the seed flag and the sticky conflict flag; the configuration registers reset to zero.
`default_nettype none
module device_announce_address_map import dam_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [15:0] destination,
	input wire logic [7:0] payload_length,
	input wire logic [15:0] announced_short,
	input wire logic [63:0] announced_long,
	output logic done,
	output logic [1:0] status,
	output logic link_disable,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [63:0] cfg_data
);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic state_q;
	logic inject_q;
	logic seeded_q;
	logic conflict_seen_q;
	logic done_q;
	logic [1:0] status_q;
	logic [63:0] own_long_q;
	logic [63:0] center_long_q;
	logic [15:0] own_short_q;
	logic [15:0] ann_short_q;
	logic [63:0] ann_long_q;

	logic accept;
	logic bad_format;
	logic do_seed;
	logic finish;
	logic conf;
	logic [1:0] final_status;
	wr_t wr;
	scan_rec_t recs [MAP_ENTRIES+1];
	scan_rec_t last;

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = !busy && !start;
	assign accept = start && !busy;
	assign bad_format = (payload_length < MIN_LENGTH) || (destination != ANNOUNCE_DEST) ||
		(announced_short > SHORT_MAX);
	assign do_seed = accept && !bad_format && !seeded_q;

	assign done = done_q;
	assign status = status_q;
	assign link_disable = done_q && (status_q == ST_CONFLICT);

	always_comb begin
		recs[0] = '0;
		recs[0].active = inject_q;
	end

	for (genvar i = 0; i < MAP_ENTRIES; i++) begin : g_cell
		seed_t seed;
		always_comb begin
			seed = '0;
			if (i == 0) begin
				seed.en = do_seed;
				seed.lng = own_long_q;
				seed.short_addr = own_short_q;
			end else if (i == 1) begin
				seed.en = do_seed;
				seed.lng = center_long_q;
				seed.short_addr = 16'd0;
			end
		end
		dam_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.idx(IDX_W'(i)),
			.ann_short(ann_short_q),
			.ann_long(ann_long_q),
			.seed(seed),
			.wr(wr),
			.rec_in(recs[i]),
			.rec_out(recs[i+1])
		);
	end

	assign last = recs[MAP_ENTRIES];
	assign finish = (state_q == S_SCAN) && last.active;
	assign conf = conflict_seen_q || last.conflict || (last.found_v && last.found_clash);

	always_comb begin
		wr = '0;
		wr.lng = ann_long_q;
		wr.short_addr = ann_short_q;
		wr.idx = last.found_v ? last.found_idx : last.free_idx;
		final_status = ST_OK;
		if (conf) begin
			final_status = ST_CONFLICT;
		end else if (ann_long_q == LONG_UNKNOWN) begin
			final_status = ST_OK;
		end else if (!last.found_v && !last.free_v) begin
			final_status = ST_FULL;
		end else begin
			wr.en = finish;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			inject_q <= 1'b0;
			seeded_q <= 1'b0;
			conflict_seen_q <= 1'b0;
			done_q <= 1'b0;
			status_q <= ST_OK;
			own_long_q <= '0;
			center_long_q <= '0;
			own_short_q <= '0;
		end else begin
			done_q <= 1'b0;
			inject_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_OWN_LONG: own_long_q <= cfg_data;
					REG_CENTER_LONG: center_long_q <= cfg_data;
					REG_OWN_SHORT: own_short_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (bad_format) begin
					done_q <= 1'b1;
					status_q <= ST_FORMAT;
				end else begin
					state_q <= S_SCAN;
					inject_q <= 1'b1;
					seeded_q <= 1'b1;
				end
			end
			if (finish) begin
				state_q <= S_IDLE;
				done_q <= 1'b1;
				status_q <= final_status;
				conflict_seen_q <= conf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ann_short_q <= announced_short;
			ann_long_q <= announced_long;
		end
	end
endmodule
`default_nettype wire

[hw/rtl/dam_checker.sv]
// Port level assertions for the device announce address map and their binding.
`default_nettype none
module dam_checker import dam_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [15:0] destination,
	input wire logic [7:0] payload_length,
	input wire logic [15:0] announced_short,
	input wire logic done,
	input wire logic [1:0] status,
	input wire logic link_disable
);
	logic bad_format;

	assign bad_format = (payload_length < MIN_LENGTH) || (destination != ANNOUNCE_DEST) ||
		(announced_short > SHORT_MAX);

	a_link_disable: assert property (@(posedge clk) disable iff (!arst_n)
		link_disable == (done && status == ST_CONFLICT))
		else $error("link_disable does not match a conflict result");

	a_format_error: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && bad_format) |=> (done && status == ST_FORMAT && !busy))
		else $error("malformed announce did not give a format error");

	a_accept_split: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy != done))
		else $error("accepted transaction neither completed nor started a scan");
endmodule

bind device_announce_address_map dam_checker u_dam_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.destination(destination),
	.payload_length(payload_length),
	.announced_short(announced_short),
	.done(done),
	.status(status),
	.link_disable(link_disable)
);
`default_nettype wire

[dv/device_announce_address_map_checker.sv]
// Checker for the address map: mirrors the table, predicts each announce result and compares.
`timescale 1ns / 100ps
module device_announce_address_map_checker import dam_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic [15:0] destination,
	input wire logic [7:0] payload_length,
	input wire logic [15:0] announced_short,
	input wire logic [63:0] announced_long,
	input wire logic done,
	input wire logic [1:0] status,
	input wire logic link_disable,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [63:0] cfg_data,
	output int outstanding,
	output int failures
);
	typedef struct packed {
		logic [1:0] status;
		logic link_disable;
	} announce_result_t;

	logic [63:0] own_long_q;
	logic [63:0] center_long_q;
	logic [15:0] own_short_q;

	logic [63:0] map_long [MAP_ENTRIES];
	logic [15:0] map_short [MAP_ENTRIES];
	logic map_used [MAP_ENTRIES];
	logic map_valid [MAP_ENTRIES];
	logic map_conflict;

	announce_result_t expected_results [$];
	announce_result_t oldest;
	announce_result_t predicted;
	int error_count = 0;

	assign failures = error_count;

	task automatic report_mismatch(input string what, input logic [1:0] got, input logic [1:0] want);
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		error_count++;
	endtask

	function automatic logic [1:0] predict_announce(input logic [15:0] dest, input logic [7:0] len,
			input logic [15:0] sa, input logic [63:0] la);
		int slot;
		int hit_idx;
		int free_idx;
		bit hit;
		bit has_free;
		hit = 1'b0;
		has_free = 1'b0;
		hit_idx = 0;
		free_idx = 0;
		if (len < MIN_LENGTH || dest != ANNOUNCE_DEST || sa > SHORT_MAX) return ST_FORMAT;
		if (!map_used[0]) begin
			map_long[0] = own_long_q;
			map_short[0] = own_short_q;
			map_used[0] = 1'b1;
			map_valid[0] = 1'b1;
			map_long[1] = center_long_q;
			map_short[1] = '0;
			map_used[1] = 1'b1;
			map_valid[1] = 1'b1;
		end
		for (slot = 0; slot < MAP_ENTRIES; slot++) begin
			if (!map_used[slot]) begin
				free_idx = slot;
				has_free = 1'b1;
			end else if (map_long[slot] == la) begin
				hit_idx = slot;
				hit = 1'b1;
			end else if (map_valid[slot] && map_short[slot] == sa) begin
				map_valid[slot] = 1'b0;
				if (slot < 2) map_conflict = 1'b1;
			end
		end
		if (hit && hit_idx < 2 && map_short[hit_idx] != sa) map_conflict = 1'b1;
		if (map_conflict) return ST_CONFLICT;
		if (la == LONG_UNKNOWN) return ST_OK;
		if (!hit) begin
			if (!has_free) return ST_FULL;
			hit_idx = free_idx;
		end
		map_long[hit_idx] = la;
		map_short[hit_idx] = sa;
		map_used[hit_idx] = 1'b1;
		map_valid[hit_idx] = 1'b1;
		return ST_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_long_q = '0;
			center_long_q = '0;
			own_short_q = '0;
			for (int e = 0; e < MAP_ENTRIES; e++) begin
				map_long[e] = '0;
				map_short[e] = '0;
				map_used[e] = 1'b0;
				map_valid[e] = 1'b0;
			end
			map_conflict = 1'b0;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no announce pending", status, status);
				end else begin
					oldest = expected_results.pop_front();
					if (status !== oldest.status)
						report_mismatch("status", status, oldest.status);
					if (link_disable !== oldest.link_disable)
						report_mismatch("link_disable", link_disable, oldest.link_disable);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OWN_LONG: own_long_q = cfg_data;
					REG_CENTER_LONG: center_long_q = cfg_data;
					REG_OWN_SHORT: own_short_q = cfg_data[15:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				predicted.status = predict_announce(destination, payload_length, announced_short,
					announced_long);
				predicted.link_disable = (predicted.status == ST_CONFLICT);
				expected_results.push_back(predicted);
			end
			outstanding <= expected_results.size();
		end
	end
endmodule

[dv/device_announce_address_map_test.sv]
// Testbench top for the address map: clock, reset, announce and register stimulus, verdict.
`timescale 1ns / 100ps
module device_announce_address_map_test;
	import dam_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1060;
	localparam int LONG_POOL = 8;
	localparam int SHORT_POOL = 6;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [15:0] destination = '0;
	logic [7:0] payload_length = '0;
	logic [15:0] announced_short = '0;
	logic [63:0] announced_long = '0;
	logic done;
	logic [1:0] status;
	logic link_disable;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	int outstanding;
	int failures;
	int cycles = 0;

	logic [63:0] seed_own_long;
	logic [63:0] seed_center_long;
	logic [15:0] seed_own_short;
	logic [63:0] long_pool [LONG_POOL];
	logic [15:0] short_pool [SHORT_POOL];
	bit gaps_allowed;

	device_announce_address_map i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.destination(destination),
		.payload_length(payload_length),
		.announced_short(announced_short),
		.announced_long(announced_long),
		.done(done),
		.status(status),
		.link_disable(link_disable),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	device_announce_address_map_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.destination(destination),
		.payload_length(payload_length),
		.announced_short(announced_short),
		.announced_long(announced_long),
		.done(done),
		.status(status),
		.link_disable(link_disable),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.outstanding(outstanding),
		.failures(failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("device_announce_address_map: mismatch");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_announce(input logic [15:0] dest, input logic [7:0] len,
			input logic [15:0] sa, input logic [63:0] la);
		destination <= dest;
		payload_length <= len;
		announced_short <= sa;
		announced_long <= la;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(input int cycles_idle);
		start <= 1'b0;
		repeat (cycles_idle) @(posedge clk);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic send_random();
		logic [15:0] dest;
		logic [7:0] len;
		logic [15:0] sa;
		logic [63:0] la;
		dest = ANNOUNCE_DEST;
		len = 8'($urandom_range(12, 255));
		sa = short_pool[$urandom_range(0, SHORT_POOL - 1)];
		la = ($urandom_range(0, 19) == 0) ? LONG_UNKNOWN :
			long_pool[$urandom_range(0, LONG_POOL - 1)];
		if ($urandom_range(0, 6) == 0) begin
			la = rand64();
			sa = 16'($urandom);
			case ($urandom_range(0, 2))
				0: begin
					dest = 16'($urandom);
					if (dest == ANNOUNCE_DEST) dest = ~dest;
				end
				1: len = 8'($urandom_range(0, 11));
				default: sa = 16'($urandom_range(16'hfff8, 16'hffff));
			endcase
		end
		send_announce(dest, len, sa, la);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_register(REG_OWN_LONG, '1);
		write_register(REG_CENTER_LONG, '1);
		write_register(REG_OWN_SHORT, 64'hffff);
		send_announce(16'h0000, 8'd255, 16'h0000, 64'h0);
		send_announce(16'hffff, 8'd12, 16'h0001, LONG_UNKNOWN);
		send_announce(16'hfffc, 8'd12, 16'h0001, 64'h1);
		send_announce(ANNOUNCE_DEST, 8'd0, 16'h0002, 64'h2);
		pause(3);
		send_announce(ANNOUNCE_DEST, 8'd11, 16'h0002, 64'h2);
		send_announce(ANNOUNCE_DEST, 8'd12, 16'hfff8, 64'h3);
		send_announce(ANNOUNCE_DEST, 8'd255, 16'hffff, LONG_UNKNOWN);
		wait_idle();

		write_register(REG_OWN_LONG, '0);
		write_register(REG_CENTER_LONG, '0);
		write_register(REG_OWN_SHORT, '0);
		send_announce(16'h7ffd, 8'd200, 16'h5555, rand64());
		send_announce(ANNOUNCE_DEST, 8'd12, 16'haaaa | 16'hfff8, rand64());
		wait_idle();

		seed_own_long = rand64();
		seed_center_long = ($urandom_range(0, 1) == 0) ? seed_own_long : rand64();
		seed_own_short = ($urandom_range(0, 1) == 0) ? 16'hffff : 16'($urandom_range(1, 16'hfff6));
		foreach (long_pool[p]) begin
			do long_pool[p] = rand64();
			while (long_pool[p] == seed_own_long || long_pool[p] == seed_center_long ||
				long_pool[p] == LONG_UNKNOWN);
		end
		foreach (short_pool[p]) begin
			do short_pool[p] = 16'($urandom_range(1, 16'hfff6));
			while (short_pool[p] == seed_own_short);
		end
		write_register(REG_OWN_LONG, seed_own_long);
		write_register(REG_CENTER_LONG, seed_center_long);
		write_register(REG_OWN_SHORT, {48'h0, seed_own_short});

		send_announce(ANNOUNCE_DEST, 8'd12, SHORT_MAX, long_pool[0]);
		send_announce(ANNOUNCE_DEST, 8'd255, short_pool[0], long_pool[1]);
		send_announce(ANNOUNCE_DEST, 8'd13, short_pool[1], long_pool[0]);
		send_announce(ANNOUNCE_DEST, 8'd12, short_pool[0], long_pool[2]);
		send_announce(ANNOUNCE_DEST, 8'd12, 16'h0000, seed_center_long);
		send_announce(ANNOUNCE_DEST, 8'd12, short_pool[1], LONG_UNKNOWN);
		send_announce(ANNOUNCE_DEST, 8'd12, short_pool[2], long_pool[1]);
		for (int k = 3; k < LONG_POOL; k++)
			send_announce(ANNOUNCE_DEST, 8'(12 + k), short_pool[k % SHORT_POOL], long_pool[k]);
		send_announce(16'h1234, 8'd12, short_pool[0], long_pool[0]);

		for (int item_no = 0; item_no < RANDOM_ITEMS; item_no++) begin
			if (item_no % 350 == 349) begin
				wait_idle();
				write_register(2'($urandom_range(REG_OWN_LONG, REG_OWN_SHORT)), rand64());
			end
			gaps_allowed = ((item_no / 100) % 3 != 2) && (item_no < RANDOM_ITEMS - 100);
			send_random();
			if (gaps_allowed && $urandom_range(0, 3) == 0) pause($urandom_range(1, 13));
		end

		// A clash with one of the seeded entries sets the sticky conflict for the rest of the run.
		case ($urandom_range(0, 2))
			0: send_announce(ANNOUNCE_DEST, 8'd20, short_pool[0], seed_own_long);
			1: begin
				if (seed_own_short == 16'hffff)
					send_announce(ANNOUNCE_DEST, 8'd20, 16'h0000, long_pool[0]);
				else
					send_announce(ANNOUNCE_DEST, 8'd20, seed_own_short, long_pool[0]);
			end
			default: send_announce(ANNOUNCE_DEST, 8'd20, 16'h0000, long_pool[1]);
		endcase
		repeat (40) send_random();

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (MAP_ENTRIES + 4) @(posedge clk);
		if (failures == 0)
			$display("device_announce_address_map: match");
		else
			$display("device_announce_address_map: mismatch");
		$finish;
	end
endmodule

[files.f]
hw/rtl/dam_pkg.sv
hw/rtl/dam_cell.sv
hw/rtl/device_announce_address_map.sv
hw/rtl/dam_checker.sv
dv/device_announce_address_map_checker.sv
dv/device_announce_address_map_test.sv
